>>> design/ibl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ibl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // operation codes
  localparam logic [2:0] OP_APPEND   = 3'd0;
  localparam logic [2:0] OP_INSERT   = 3'd1;
  localparam logic [2:0] OP_POP      = 3'd2;
  localparam logic [2:0] OP_REMOVE   = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;
  localparam logic [2:0] OP_FIND     = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // cell commands
  localparam logic [1:0] CMD_HOLD    = 2'd0;
  localparam logic [1:0] CMD_INSERT  = 2'd1;
  localparam logic [1:0] CMD_DELETE  = 2'd2;

  typedef struct packed {
    logic [2:0] operation;
    logic [4:0] position;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] found_at;
    logic [4:0] length;
    logic [2:0] status;
  } rsp_t;

  // broadcast to every cell each cycle
  typedef struct packed {
    logic [1:0]       kind;
    logic [CMP_W-1:0] target;
    logic [7:0]       value;
    logic [CNT_W-1:0] count;
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> design/ibl_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ibl_cell (
  input  wire                    clk,
  input  ibl_pkg::cell_cmd_t     cmd,
  input  wire [ibl_pkg::IDX_W-1:0] idx,
  input  wire [7:0]              left,
  input  wire [7:0]              right,
  output logic [7:0]             entry,
  input  wire [7:0]              data_in,
  output logic [7:0]             data_out,
  input  wire                    hit_in,
  input  wire [ibl_pkg::IDX_W-1:0] at_in,
  output logic                   hit_out,
  output logic [ibl_pkg::IDX_W-1:0] at_out
);
  import ibl_pkg::*;

  logic [CMP_W-1:0] my_pos;
  logic [7:0]       entry_next;
  logic             match;

  assign my_pos = CMP_W'(idx);

  always_comb begin
    entry_next = entry;
    unique case (cmd.kind)
      CMD_INSERT: begin
        if (my_pos == cmd.target) entry_next = cmd.value;
        else if (my_pos > cmd.target) entry_next = left;
      end
      CMD_DELETE: begin
        if (my_pos >= cmd.target) entry_next = right;
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  // read chain: selected cell ORs its byte in
  assign data_out = data_in | ((my_pos == cmd.target) ? entry : 8'h00);

  // first-match chain, only live entries count
  assign match   = (entry == cmd.value) && (CNT_W'(idx) < cmd.count);
  assign hit_out = hit_in | match;
  assign at_out  = hit_in ? at_in : idx;

endmodule

`default_nettype wire

>>> design/indexed_byte_list.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake            Payload
// req       in   req_valid/req_stall  ibl_pkg::req_t (operation, position, value)
// rsp       out  rsp_valid/rsp_stall  ibl_pkg::rsp_t (data, found_at, length, status)
//
// One item per cycle unless the input is stalled: a row of CAPACITY cells
// shifts, compares and selects in the accept cycle; the result is registered.
// Read and find travel as chains through the cells, so the row length sets
// the combinational depth.
// Reset clears the entry count and the output valid; cell contents are left
// undefined and are only read below the count.
// A held result stalls the input only while rsp_stall is high.

module indexed_byte_list (
  input  wire            clk,
  input  wire            rst,
  input  wire            req_valid,
  output logic           req_stall,
  input  ibl_pkg::req_t  req,
  output logic           rsp_valid,
  input  wire            rsp_stall,
  output ibl_pkg::rsp_t  rsp
);
  import ibl_pkg::*;

  logic             accept;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CMP_W-1:0] pos;
  logic [CMP_W-1:0] cnt_ext;
  logic             empty;
  logic             full;
  logic [2:0]       status;
  logic             want_data;
  logic             want_found;
  cell_cmd_t        cmd;
  rsp_t             rsp_next;

  logic [7:0]       entry  [CAPACITY];
  logic [7:0]       data_c [CAPACITY+1];
  logic             hit_c  [CAPACITY+1];
  logic [IDX_W-1:0] at_c   [CAPACITY+1];

  // Output register doubles as the skid stage.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign pos     = CMP_W'(req.position);
  assign cnt_ext = CMP_W'(count);
  assign empty   = (count == '0);
  assign full    = (cnt_ext >= CMP_W'(CAPACITY));

  // Decode the item into one cell command plus status.
  always_comb begin
    status       = ST_OK;
    want_data    = 1'b0;
    want_found   = 1'b0;
    count_next   = count;
    cmd.kind     = CMD_HOLD;
    cmd.target   = pos;
    cmd.value    = req.value;
    cmd.count    = count;
    unique case (req.operation)
      OP_APPEND: begin
        cmd.target = cnt_ext;
        if (full) status = ST_FULL;
        else begin
          cmd.kind   = CMD_INSERT;
          count_next = count + 1'b1;
        end
      end
      OP_INSERT: begin
        if (pos > cnt_ext) status = ST_RANGE;
        else if (full) status = ST_FULL;
        else begin
          cmd.kind   = CMD_INSERT;
          count_next = count + 1'b1;
        end
      end
      OP_POP: begin
        cmd.target = cnt_ext - 1'b1;
        if (empty) status = ST_EMPTY;
        else begin
          cmd.kind   = CMD_DELETE;
          want_data  = 1'b1;
          count_next = count - 1'b1;
        end
      end
      OP_REMOVE: begin
        if (empty) status = ST_EMPTY;
        else if (pos >= cnt_ext) status = ST_RANGE;
        else begin
          cmd.kind   = CMD_DELETE;
          want_data  = 1'b1;
          count_next = count - 1'b1;
        end
      end
      OP_READ: begin
        if (empty) status = ST_EMPTY;
        else if (pos >= cnt_ext) status = ST_RANGE;
        else want_data = 1'b1;
      end
      OP_FIND: begin
        // hit or miss is settled at the end of the chain
        if (empty) status = ST_EMPTY;
        else want_found = 1'b1;
      end
      default: status = ST_OK;  // unused codes do nothing
    endcase
    if (!accept) cmd.kind = CMD_HOLD;
  end

  assign data_c[0] = 8'h00;
  assign hit_c[0]  = 1'b0;
  assign at_c[0]   = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [7:0] left_nb;
    logic [7:0] right_nb;
    if (i == 0) begin : g_first
      assign left_nb = req.value;
    end else begin : g_left
      assign left_nb = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_nb = 8'h00;
    end else begin : g_right
      assign right_nb = entry[i+1];
    end
    ibl_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .idx      (IDX_W'(i)),
      .left     (left_nb),
      .right    (right_nb),
      .entry    (entry[i]),
      .data_in  (data_c[i]),
      .data_out (data_c[i+1]),
      .hit_in   (hit_c[i]),
      .at_in    (at_c[i]),
      .hit_out  (hit_c[i+1]),
      .at_out   (at_c[i+1])
    );
  end

  always_comb begin
    rsp_next.data     = want_data ? data_c[CAPACITY] : 8'h00;
    rsp_next.found_at = (want_found && hit_c[CAPACITY]) ? 4'(at_c[CAPACITY]) : 4'd0;
    rsp_next.length   = 5'(count_next);
    rsp_next.status   = (want_found && !hit_c[CAPACITY]) ? ST_NOTFOUND : status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) rsp <= rsp_next;
  end

endmodule

`default_nettype wire
